// File: src/lfu_pkg.sv
`timescale 1ns / 1ps
package lfu_pkg;
  localparam int DEF_ENTRIES    = 16;
  localparam int DEF_COUNT_BITS = 16;
  localparam int KEY_BITS       = 32;
  localparam int VAL_BITS       = 32;
  localparam int CAP_BITS       = 5;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;
endpackage

// File: src/lfu_mem.sv
`timescale 1ns / 1ps
module lfu_mem import lfu_pkg::*; #(
  parameter int W     = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);
  logic [W-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: src/lfu_cache_table_unit.sv
`timescale 1ns / 1ps
// channel | dir | tdata/data fields (low bit up)
// s_axis  | in  | lookup_key[31:0] write_value[63:32]; tuser = cmd
// m_axis  | out | read_value[31:0] evicted_key[63:32]; tuser = hit, evicted
// cfg     | in  | capacity[4:0]
// an item is handled by sweeps of the slot memory (one read port, one write
// port): the key/victim scan, then for hits and stored puts the rank update
// sweep(s) and the write of the slot
// reset clears valid bits, fill level and capacity (to 16), no clearing pass
// a result waits in the output register; the next word is taken only after
// it has left, so m_axis_tready stalls the whole block
module lfu_cache_table_unit import lfu_pkg::*; #(
  parameter int ENTRIES    = DEF_ENTRIES,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [63:0]         s_axis_tdata,   // lookup_key, write_value
  input  logic                s_axis_tuser,   // cmd
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [63:0]         m_axis_tdata,   // read_value, evicted_key
  output logic [1:0]          m_axis_tuser,   // hit, evicted
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CAP_BITS-1:0] cfg_data        // capacity
);
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int FW = $clog2(ENTRIES + 1);
  localparam int RW = AW;
  localparam int MW = KEY_BITS + VAL_BITS + COUNT_BITS + RW;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_DEC = 3'd2,
                         S_UPD = 3'd3, S_WR = 3'd4, S_OUT = 3'd5;

  logic [2:0] state;
  logic [CAP_BITS-1:0] capacity;
  logic [ENTRIES-1:0] valid;
  logic [FW-1:0] fill;
  logic cmd;
  logic [KEY_BITS-1:0] key;
  logic [VAL_BITS-1:0] val;
  // sweep counters: issue address and returning address
  logic [AW:0] ra;
  logic [AW:0] da;
  logic        dv;
  // scan results
  logic found;
  logic [AW-1:0] fslot;
  logic [RW-1:0] frank;
  logic [COUNT_BITS-1:0] fcnt;
  logic [VAL_BITS-1:0] fval;
  logic vfound;
  logic [AW-1:0] vslot;
  logic [COUNT_BITS-1:0] vcnt;
  logic [RW-1:0] vrank;
  logic [KEY_BITS-1:0] vkey;
  logic efound;
  logic [AW-1:0] eslot;
  // sweep mode for rank update
  logic [1:0] mode; // 0 touch, 1 evict-decrement, 2 insert-increment
  logic [RW-1:0] pivot;
  // outputs
  logic o_hit, o_ev;
  logic [VAL_BITS-1:0] o_val;
  logic [KEY_BITS-1:0] o_key;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [MW-1:0] wdata, rdata;

  lfu_mem #(.W(MW), .DEPTH(ENTRIES), .AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  logic [KEY_BITS-1:0] r_key;
  logic [VAL_BITS-1:0] r_val;
  logic [COUNT_BITS-1:0] r_cnt;
  logic [RW-1:0] r_rank;
  assign {r_key, r_val, r_cnt, r_rank} = rdata;

  logic [CAP_BITS-1:0] cap_eff;
  assign cap_eff = (int'(capacity) > ENTRIES) ? CAP_BITS'(ENTRIES) : capacity;

  logic sweep_last;
  assign sweep_last = dv && (da[AW-1:0] == AW'(ENTRIES - 1));
  logic dvalid;
  assign dvalid = dv && valid[da[AW-1:0]];

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = {o_key, o_val};
  assign m_axis_tuser  = {o_ev, o_hit};
  assign raddr = ra[AW-1:0];

  // rank update: write back entry at da with adjusted rank; in S_WR, write the slot itself
  always_comb begin
    we = 1'b0;
    waddr = da[AW-1:0];
    wdata = rdata;
    if (state == S_UPD && dvalid) begin
      unique case (mode)
        2'd0: if (r_rank < pivot) begin
          we = 1'b1; wdata = {r_key, r_val, r_cnt, r_rank + RW'(1)};
        end
        2'd1: if (r_rank > pivot) begin
          we = 1'b1; wdata = {r_key, r_val, r_cnt, r_rank - RW'(1)};
        end
        default: begin
          we = 1'b1; wdata = {r_key, r_val, r_cnt, r_rank + RW'(1)};
        end
      endcase
    end else if (state == S_WR) begin
      we = 1'b1;
      if (found) begin
        waddr = fslot;
        wdata = {key, (cmd == CMD_PUT) ? val : fval,
                 (fcnt == CMAX) ? fcnt : fcnt + COUNT_BITS'(1), RW'(0)};
      end else begin
        waddr = eslot;
        wdata = {key, val, COUNT_BITS'(1), RW'(0)};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      capacity <= CAP_RESET;
      valid <= '0;
      fill <= '0;
      dv <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cfg_valid) capacity <= cfg_data;
          if (s_axis_tvalid) begin
            cmd <= s_axis_tuser;
            key <= s_axis_tdata[KEY_BITS-1:0];
            val <= s_axis_tdata[63:32];
            found <= 1'b0; vfound <= 1'b0; efound <= 1'b0;
            o_hit <= 1'b0; o_ev <= 1'b0; o_val <= '1; o_key <= '0;
            ra <= '0; dv <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // dv drops by itself once ra has reached ENTRIES
          if (ra != (AW+1)'(ENTRIES)) ra <= ra + 1'b1;
          dv <= (ra != (AW+1)'(ENTRIES));
          da <= ra;
          if (dvalid) begin
            if (!found && r_key == key) begin
              found <= 1'b1; fslot <= da[AW-1:0]; frank <= r_rank;
              fcnt <= r_cnt; fval <= r_val;
            end
            if (!vfound || r_cnt < vcnt || (r_cnt == vcnt && r_rank > vrank)) begin
              vfound <= 1'b1; vslot <= da[AW-1:0]; vcnt <= r_cnt;
              vrank <= r_rank; vkey <= r_key;
            end
          end else if (dv && !efound) begin
            efound <= 1'b1; eslot <= da[AW-1:0];
          end
          if (sweep_last) begin
            ra <= '0;
            if (cmd == CMD_PUT && cap_eff == '0) begin
              // storing disabled: put reports a plain miss
              state <= S_OUT;
            end else if (found || (!dvalid ? 1'b0 : r_key == key)) begin
              // hit: touch sweep then write
              o_hit <= 1'b1;
              if (cmd == CMD_GET)
                o_val <= found ? fval : r_val;
              mode <= 2'd0;
              pivot <= found ? frank : r_rank;
              state <= S_UPD;
            end else if (cmd == CMD_GET) begin
              state <= S_OUT;
            end else if (fill >= FW'(cap_eff)) begin
              state <= S_DEC;
            end else begin
              mode <= 2'd2;
              state <= S_UPD;
            end
          end
        end
        S_DEC: begin
          // evict victim, then decrement ranks above it
          o_ev <= 1'b1; o_key <= vkey;
          valid[vslot] <= 1'b0;
          fill <= fill - 1'b1;
          efound <= 1'b1; eslot <= vslot;
          mode <= 2'd1; pivot <= vrank;
          state <= S_UPD;
        end
        S_UPD: begin
          if (ra != (AW+1)'(ENTRIES)) ra <= ra + 1'b1;
          dv <= (ra != (AW+1)'(ENTRIES));
          da <= ra;
          if (sweep_last) begin
            ra <= '0;
            if (mode == 2'd1) mode <= 2'd2;
            else state <= S_WR;
          end
        end
        S_WR: begin
          if (!found) begin
            valid[eslot] <= 1'b1;
            fill <= fill + 1'b1;
          end
          state <= S_OUT;
        end
        S_OUT: if (m_axis_tready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: sim/lfu_cache_table_unit_tb.sv
`timescale 1ns / 1ps
module lfu_cache_table_unit_tb;
  import lfu_pkg::*;

  localparam int NSLOT = 16;
  localparam int CNT_MAX = 65535;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 120;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
    logic        evicted;
    logic [31:0] evicted_key;
  } lfu_result_t;

  // scoreboard: holds a shadow of the table and the results still owed
  class lfu_scoreboard;
    bit          valid_q[NSLOT];
    logic [31:0] key_q[NSLOT];
    logic [31:0] val_q[NSLOT];
    int unsigned cnt_q[NSLOT];
    int unsigned rank_q[NSLOT];
    int unsigned fill;
    int unsigned cap;
    lfu_result_t owed_q[$];
    int errors;

    function new();
      cap = NSLOT;
      fill = 0;
      errors = 0;
      foreach (valid_q[i]) valid_q[i] = 0;
    endfunction

    function void set_capacity(logic [CAP_BITS-1:0] c);
      cap = (c > NSLOT) ? NSLOT : c;
    endfunction

    function int find(logic [31:0] k);
      for (int i = 0; i < NSLOT; i++)
        if (valid_q[i] && key_q[i] == k) return i;
      return -1;
    endfunction

    function void touch(int s);
      int unsigned r;
      r = rank_q[s];
      for (int i = 0; i < NSLOT; i++)
        if (valid_q[i] && rank_q[i] < r) rank_q[i]++;
      rank_q[s] = 0;
      if (cnt_q[s] < CNT_MAX) cnt_q[s]++;
    endfunction

    // note an accepted input word and queue its result
    function void note_input(logic cmd, logic [31:0] k, logic [31:0] v);
      lfu_result_t res;
      int s, slot;
      int unsigned r;
      res = '{1'b0, 32'hFFFF_FFFF, 1'b0, 32'd0};
      s = find(k);
      if (cmd == CMD_GET) begin
        if (s >= 0) begin
          res.hit = 1;
          res.read_value = val_q[s];
          touch(s);
        end
      end else if (cap != 0) begin
        if (s >= 0) begin
          res.hit = 1;
          val_q[s] = v;
          touch(s);
        end else begin
          slot = -1;
          if (fill >= cap) begin
            for (int i = 0; i < NSLOT; i++) begin
              if (!valid_q[i]) continue;
              if (slot < 0 || cnt_q[i] < cnt_q[slot] ||
                  (cnt_q[i] == cnt_q[slot] && rank_q[i] > rank_q[slot]))
                slot = i;
            end
            if (slot >= 0) begin
              r = rank_q[slot];
              res.evicted = 1;
              res.evicted_key = key_q[slot];
              valid_q[slot] = 0;
              for (int i = 0; i < NSLOT; i++)
                if (valid_q[i] && rank_q[i] > r) rank_q[i]--;
              fill--;
            end
          end
          if (slot < 0)
            for (int i = 0; i < NSLOT; i++)
              if (!valid_q[i]) begin
                slot = i;
                break;
              end
          if (slot >= 0) begin
            for (int i = 0; i < NSLOT; i++)
              if (valid_q[i]) rank_q[i]++;
            valid_q[slot] = 1;
            key_q[slot] = k;
            val_q[slot] = v;
            cnt_q[slot] = 1;
            rank_q[slot] = 0;
            fill++;
          end
        end
      end
      owed_q.push_back(res);
    endfunction

    function void check_result(lfu_result_t got);
      lfu_result_t exp_r;
      if (owed_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_r = owed_q.pop_front();
      if (got !== exp_r) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp hit %b rv %h ev %b ek %h / got hit %b rv %h ev %b ek %h",
                   exp_r.hit, exp_r.read_value, exp_r.evicted, exp_r.evicted_key,
                   got.hit, got.read_value, got.evicted, got.evicted_key);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // lookup_key, write_value
  logic        s_axis_tuser;   // cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;   // read_value, evicted_key
  logic [1:0]  m_axis_tuser;   // hit, evicted
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CAP_BITS-1:0] cfg_data;

  lfu_scoreboard sb;
  int idle_cycles;
  bit timed_out;
  logic [31:0] key_pool[8];

  lfu_cache_table_unit dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // receiver stall pattern: alternates calm and choppy stretches
  initial begin
    int phase;
    m_axis_tready = 0;
    phase = 0;
    forever begin
      @(negedge clk);
      phase++;
      if ((phase / 300) % 3 == 0) m_axis_tready <= 1;
      else m_axis_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // output monitor and watchdog
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result('{m_axis_tuser[0], m_axis_tdata[31:0],
                          m_axis_tuser[1], m_axis_tdata[63:32]});
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
          (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
        timed_out = 1;
        $display("tb: failure");
        $finish;
      end
    end
  end

  // one word on the input side, noted once the handshake completes
  task automatic send_word(logic cmd, logic [31:0] k, logic [31:0] v);
    s_axis_tvalid <= 1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {v, k};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(cmd, k, v);
    @(negedge clk);
  endtask

  task automatic pause_sender();
    s_axis_tvalid <= 0;
    repeat ($urandom_range(1, 20)) @(negedge clk);
  endtask

  // wait until nothing is owed, then let the block settle before a write
  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.owed_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_capacity(logic [CAP_BITS-1:0] c);
    cfg_valid <= 1;
    cfg_data <= c;
    do @(posedge clk); while (!cfg_ready);
    sb.set_capacity(c);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 9) < 8) return key_pool[$urandom_range(0, 7)];
    return $urandom();
  endfunction

  // random phase: bursts over a small key pool so hits and evictions are common
  task automatic random_phase(int n);
    int burst;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        pause_sender();
        burst = $urandom_range(1, 40);
      end
      burst--;
      send_word(1'($urandom_range(0, 1)), pick_key(), $urandom());
    end
  endtask

  initial begin
    logic [CAP_BITS-1:0] caps[6];
    sb = new();
    timed_out = 0;
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    s_axis_tuser = CMD_GET;
    cfg_valid = 0;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: extreme keys and values, miss, hit, update, get on empty
    send_word(CMD_GET, 32'h0, 32'h0);
    send_word(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_word(CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(CMD_GET, 32'h8000_0000, 32'hFFFF_FFFF);
    send_word(CMD_PUT, 32'h7FFF_FFFF, 32'h0);
    send_word(CMD_GET, 32'h7FFF_FFFF, 32'h0);
    send_word(CMD_GET, 32'h1234_5678, 32'h0);
    drain();

    // small capacity: evictions take the entry with the lowest count
    write_capacity(5'd2);
    send_word(CMD_PUT, 32'd1, 32'd10);
    send_word(CMD_GET, 32'd1, 32'd0);
    send_word(CMD_PUT, 32'd2, 32'd20);
    send_word(CMD_PUT, 32'd3, 32'd30);
    send_word(CMD_PUT, 32'd4, 32'd40);
    drain();

    // capacity zero: puts do nothing, gets still search
    write_capacity(5'd0);
    send_word(CMD_PUT, 32'd5, 32'd50);
    send_word(CMD_GET, 32'd1, 32'd0);
    drain();

    // capacity above the table size saturates
    write_capacity(5'd31);
    for (int i = 0; i < 18; i++) send_word(CMD_PUT, 32'd100 + i, i);
    drain();

    // lowered below the fill level: one eviction per new key
    write_capacity(5'd1);
    send_word(CMD_PUT, 32'd999, 32'd1);
    drain();

    caps = '{5'd16, 5'd1, 5'd4, 5'd0, 5'd8, 5'd31};
    foreach (caps[c]) begin
      write_capacity(caps[c]);
      foreach (key_pool[i])
        key_pool[i] = ($urandom_range(0, 1) != 0) ? $urandom() : $urandom_range(0, 20);
      random_phase(260);
      drain();
    end

    // a hot key keeps its slot while cold keys churn
    write_capacity(5'd3);
    send_word(CMD_PUT, 32'd77, 32'd7);
    for (int i = 0; i < 4; i++) send_word(CMD_GET, 32'd77, 32'd0);
    send_word(CMD_PUT, 32'd78, 32'd8);
    send_word(CMD_PUT, 32'd79, 32'd9);
    send_word(CMD_PUT, 32'd80, 32'd9);
    drain();

    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// File: sim.f
src/lfu_pkg.sv
src/lfu_mem.sv
src/lfu_cache_table_unit.sv
sim/lfu_cache_table_unit_tb.sv
